// ===== design/jbb_pkg.sv =====
package jbb_pkg;

  localparam int STACK_DEPTH_DEFAULT   = 64;
  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int OPEN_POSITION_W       = 16;
  localparam int NESTING_DEPTH_W       = 7;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;

  localparam logic KIND_OBJECT = 1'b0;
  localparam logic KIND_ARRAY  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BALANCED    = 3'd1,
    ST_MISMATCH    = 3'd2,
    ST_UNTERMINATED = 3'd3,
    ST_NOTHING_OPEN = 3'd4,
    ST_TOO_DEEP    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } text_req_t;

  typedef struct packed {
    status_t                      status;
    logic                         open_kind;
    logic [OPEN_POSITION_W-1:0]   open_position;
    logic [NESTING_DEPTH_W-1:0]   nesting_depth;
  } verdict_t;

endpackage

// ===== design/json_bracket_balance_checker.sv =====
// An accepted request is registered, and its verdict is registered from it.
// Throughput: one text byte per cycle unless verdict_stall holds; the top of the
// nesting stack is registered; the level below is prefetched from stack memory.
// Reset: rst clears all control state; stack memory contents are not cleared.
// The request flagged as the final byte clears the stack and parse state.
module json_bracket_balance_checker #(
  parameter int STACK_DEPTH   = jbb_pkg::STACK_DEPTH_DEFAULT,
  parameter int POSITION_BITS = jbb_pkg::POSITION_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  input  jbb_pkg::text_req_t text_req,
  output logic               verdict_valid,
  input  logic               verdict_stall,
  output jbb_pkg::verdict_t  verdict
);
  import jbb_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = POSITION_BITS + 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [EW-1:0] stack_mem [STACK_DEPTH];

  text_req_t          req_reg;
  logic               req_full;
  logic [CW-1:0]      stack_count, stack_count_next;
  logic               in_quotes, in_quotes_next;
  logic               skip_next_quote, skip_next_quote_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  status_t            err_status, err_status_next;
  logic               err_kind, err_kind_next;
  logic [POSITION_BITS-1:0] err_pos, err_pos_next;
  logic [EW-1:0]      top_entry, top_entry_next;
  logic [EW-1:0]      below_entry;
  verdict_t           verdict_next;

  logic fire, accept, push, pop;
  logic [7:0] c;
  logic fin, ws, is_closer, is_opener, kind_c, tk, quotes_now;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [CW-1:0] wr_idx, rd_idx;

  assign fire       = req_full && (!verdict_valid || !verdict_stall);
  assign text_stall = req_full && !fire;
  assign accept     = text_valid && !text_stall;

  assign c         = req_reg.text_byte;
  assign fin       = req_reg.final_byte;
  assign ws        = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
                     (c == CH_LF) || (c == CH_COMMA);
  assign is_closer = (c == CH_RBRACE) || (c == CH_RBRACKET);
  assign is_opener = (c == CH_LBRACE) || (c == CH_LBRACKET);
  assign kind_c    = (c == CH_RBRACKET) || (c == CH_LBRACKET);
  assign tk        = top_entry[EW-1];

  assign wr_idx  = stack_count - CW'(1);
  assign rd_idx  = stack_count - CW'(3);
  assign wr_addr = wr_idx[AW-1:0];
  assign rd_addr = rd_idx[AW-1:0];

  always_comb begin
    stack_count_next     = stack_count;
    in_quotes_next       = in_quotes;
    skip_next_quote_next = skip_next_quote;
    err_status_next      = err_status;
    err_kind_next        = err_kind;
    err_pos_next         = err_pos;
    top_entry_next       = top_entry;
    byte_position_next   = byte_position;
    push                 = 1'b0;
    pop                  = 1'b0;
    quotes_now           = in_quotes;
    verdict_next         = verdict;

    if (fire) begin
      if (byte_position != POS_MAX) begin
        byte_position_next = byte_position + POSITION_BITS'(1);
      end

      if (err_status == ST_OK && !ws) begin
        if (!in_quotes && is_closer && stack_count == '0) begin
          err_status_next = ST_NOTHING_OPEN;
          err_kind_next   = kind_c;
          err_pos_next    = byte_position;
        end else if (!in_quotes && is_closer && tk != kind_c) begin
          err_status_next = ST_MISMATCH;
          err_kind_next   = tk;
          err_pos_next    = top_entry[POSITION_BITS-1:0];
        end else if (!in_quotes && is_closer) begin
          pop              = 1'b1;
          stack_count_next = stack_count - CW'(1);
          top_entry_next   = below_entry;
          skip_next_quote_next = 1'b0;
        end else begin
          if (c == CH_QUOTE && !skip_next_quote) begin
            quotes_now = !in_quotes;
          end
          in_quotes_next = quotes_now;
          if (!quotes_now && is_opener && stack_count == CW'(STACK_DEPTH)) begin
            err_status_next = ST_TOO_DEEP;
            err_kind_next   = kind_c;
            err_pos_next    = byte_position;
          end else begin
            if (!quotes_now && is_opener) begin
              push             = 1'b1;
              stack_count_next = stack_count + CW'(1);
              top_entry_next   = {kind_c, byte_position};
            end
            skip_next_quote_next = quotes_now && (c == CH_BACKSLASH) && !skip_next_quote;
          end
        end
      end

      verdict_next.nesting_depth = NESTING_DEPTH_W'(stack_count_next);
      if (err_status_next != ST_OK) begin
        verdict_next.status        = err_status_next;
        verdict_next.open_kind     = err_kind_next;
        verdict_next.open_position = OPEN_POSITION_W'(err_pos_next);
      end else if (!fin) begin
        verdict_next.status        = ST_OK;
        verdict_next.open_kind     = KIND_OBJECT;
        verdict_next.open_position = '0;
      end else if (stack_count_next != '0) begin
        verdict_next.status        = ST_UNTERMINATED;
        verdict_next.open_kind     = top_entry_next[EW-1];
        verdict_next.open_position = OPEN_POSITION_W'(top_entry_next[POSITION_BITS-1:0]);
      end else begin
        verdict_next.status        = ST_BALANCED;
        verdict_next.open_kind     = KIND_OBJECT;
        verdict_next.open_position = '0;
      end

      if (fin) begin
        stack_count_next     = '0;
        in_quotes_next       = 1'b0;
        skip_next_quote_next = 1'b0;
        byte_position_next   = '0;
        err_status_next      = ST_OK;
        err_kind_next        = 1'b0;
        err_pos_next         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && stack_count != '0) begin
      stack_mem[wr_addr] <= top_entry;
    end
    if (pop && stack_count >= CW'(3)) begin
      below_entry <= stack_mem[rd_addr];
    end else if (push) begin
      below_entry <= top_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_reg <= text_req;
    end
    top_entry <= top_entry_next;
    verdict   <= verdict_next;
    err_kind  <= err_kind_next;
    err_pos   <= err_pos_next;
    if (rst) begin
      req_full        <= 1'b0;
      verdict_valid   <= 1'b0;
      stack_count     <= '0;
      in_quotes       <= 1'b0;
      skip_next_quote <= 1'b0;
      byte_position   <= '0;
      err_status      <= ST_OK;
    end else begin
      if (accept) begin
        req_full <= 1'b1;
      end else if (fire) begin
        req_full <= 1'b0;
      end
      if (fire) begin
        verdict_valid <= 1'b1;
      end else if (!verdict_stall) begin
        verdict_valid <= 1'b0;
      end
      stack_count     <= stack_count_next;
      in_quotes       <= in_quotes_next;
      skip_next_quote <= skip_next_quote_next;
      byte_position   <= byte_position_next;
      err_status      <= err_status_next;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import jbb_pkg::*;

  localparam int LEVELS = STACK_DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 1420;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic text_valid = 1'b0;
  logic text_stall;
  text_req_t text_req = '0;
  logic verdict_valid;
  logic verdict_stall = 1'b0;
  verdict_t verdict;

  verdict_t verdict_q[$];
  verdict_t want_verdict;
  int mismatches = 0;
  int verdict_count = 0;
  int requests_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_run = 0;

  logic [16:0] open_levels [LEVELS];
  int open_count;
  bit in_string;
  bit escape_armed;
  logic [15:0] next_position;
  status_t held_status;
  logic held_kind;
  logic [15:0] held_position;

  logic [7:0] text_buf[$];
  logic gen_kinds[$];
  logic [7:0] blank_chars [5] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COMMA};

  json_bracket_balance_checker u_top (
    .clk(clk),
    .rst(rst),
    .text_valid(text_valid),
    .text_stall(text_stall),
    .text_req(text_req),
    .verdict_valid(verdict_valid),
    .verdict_stall(verdict_stall),
    .verdict(verdict)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void clear_predictor();
    open_count = 0;
    in_string = 1'b0;
    escape_armed = 1'b0;
    next_position = '0;
    held_status = ST_OK;
    held_kind = KIND_OBJECT;
    held_position = '0;
  endfunction

  function automatic void hold_error(input status_t st, input logic kind_now,
                                     input logic [15:0] pos);
    held_status = st;
    held_kind = kind_now;
    held_position = pos;
  endfunction

  function automatic verdict_t predict_verdict(input text_req_t r);
    verdict_t v;
    logic [7:0] c;
    logic [15:0] pos;
    logic kind_now;
    logic [16:0] top;
    bit was_escaped;
    bit halted;
    c = r.text_byte;
    pos = next_position;
    halted = 1'b0;
    if (next_position != 16'hFFFF) next_position++;
    if (held_status == ST_OK && !(c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COMMA})) begin
      was_escaped = escape_armed;
      if (!in_string && (c == CH_RBRACE || c == CH_RBRACKET)) begin
        kind_now = (c == CH_RBRACKET) ? KIND_ARRAY : KIND_OBJECT;
        if (open_count == 0) begin
          hold_error(ST_NOTHING_OPEN, kind_now, pos);
          halted = 1'b1;
        end else begin
          top = open_levels[open_count-1];
          if (top[16] != kind_now) begin
            hold_error(ST_MISMATCH, top[16], top[15:0]);
            halted = 1'b1;
          end else begin
            open_count--;
          end
        end
      end
      if (!halted && c == CH_QUOTE && !was_escaped) in_string = !in_string;
      if (!halted && !in_string && (c == CH_LBRACE || c == CH_LBRACKET)) begin
        kind_now = (c == CH_LBRACKET) ? KIND_ARRAY : KIND_OBJECT;
        if (open_count >= LEVELS) begin
          hold_error(ST_TOO_DEEP, kind_now, pos);
          halted = 1'b1;
        end else begin
          open_levels[open_count] = {kind_now, pos};
          open_count++;
        end
      end
      if (!halted) escape_armed = in_string && c == CH_BACKSLASH && !was_escaped;
    end
    v.open_kind = KIND_OBJECT;
    v.open_position = '0;
    if (held_status != ST_OK) begin
      v.status = held_status;
      v.open_kind = held_kind;
      v.open_position = held_position;
    end else if (!r.final_byte) begin
      v.status = ST_OK;
    end else if (open_count > 0) begin
      top = open_levels[open_count-1];
      v.status = ST_UNTERMINATED;
      v.open_kind = top[16];
      v.open_position = top[15:0];
    end else begin
      v.status = ST_BALANCED;
    end
    v.nesting_depth = 7'(open_count);
    if (r.final_byte) clear_predictor();
    return v;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t ns verdict %0d: %s got %0d expected %0d",
               $time, verdict_count, field, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && verdict_valid && !verdict_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with no request pending, status",
                        int'(verdict.status), -1);
      end else begin
        want_verdict = verdict_q.pop_front();
        if (verdict.status !== want_verdict.status)
          report_mismatch("status", int'(verdict.status), int'(want_verdict.status));
        if (verdict.open_kind !== want_verdict.open_kind)
          report_mismatch("open_kind", int'(verdict.open_kind),
                          int'(want_verdict.open_kind));
        if (verdict.open_position !== want_verdict.open_position)
          report_mismatch("open_position", int'(verdict.open_position),
                          int'(want_verdict.open_position));
        if (verdict.nesting_depth !== want_verdict.nesting_depth)
          report_mismatch("nesting_depth", int'(verdict.nesting_depth),
                          int'(want_verdict.nesting_depth));
      end
      verdict_count++;
    end
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run = $urandom_range(10, 60);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0: begin
        verdict_stall <= 1'b0;
      end
      1: begin
        verdict_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        verdict_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        verdict_stall <= (stall_run % 8) < 3;
      end
    endcase
  end

  task automatic send_text(input logic [7:0] b, input logic fin);
    text_req_t r;
    int idle;
    r.text_byte = b;
    r.final_byte = fin;
    if (burst_left == 0) begin
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle > 0) begin
        text_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    text_valid <= 1'b1;
    text_req <= r;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    verdict_q.push_back(predict_verdict(r));
    requests_sent++;
  endtask

  task automatic send_buffer();
    foreach (text_buf[i]) send_text(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_literal(input string s);
    for (int i = 0; i < s.len(); i++) send_text(s[i], i == s.len() - 1);
  endtask

  task automatic push_openers(input int n);
    logic k;
    repeat (n) begin
      k = 1'($urandom_range(0, 1));
      text_buf.push_back(k == KIND_ARRAY ? CH_LBRACKET : CH_LBRACE);
      gen_kinds.push_back(k);
      if ($urandom_range(0, 3) == 0) text_buf.push_back(blank_chars[$urandom_range(0, 4)]);
    end
  endtask

  task automatic push_closers(input int n);
    logic k;
    repeat (n) begin
      if (gen_kinds.size() > 0) begin
        k = gen_kinds.pop_back();
        text_buf.push_back(k == KIND_ARRAY ? CH_RBRACKET : CH_RBRACE);
      end
    end
  endtask

  task automatic push_string();
    int n;
    n = $urandom_range(0, 6);
    text_buf.push_back(CH_QUOTE);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: begin
          text_buf.push_back(CH_BACKSLASH);
          case ($urandom_range(0, 3))
            0: text_buf.push_back(CH_QUOTE);
            1: text_buf.push_back(CH_BACKSLASH);
            2: text_buf.push_back(blank_chars[$urandom_range(0, 4)]);
            default: text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
          endcase
        end
        1: begin
          case ($urandom_range(0, 3))
            0: text_buf.push_back(CH_LBRACE);
            1: text_buf.push_back(CH_RBRACE);
            2: text_buf.push_back(CH_LBRACKET);
            default: text_buf.push_back(CH_RBRACKET);
          endcase
        end
        2: text_buf.push_back(blank_chars[$urandom_range(0, 4)]);
        default: text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
      endcase
    end
    if ($urandom_range(0, 15) != 0) text_buf.push_back(CH_QUOTE);
  endtask

  task automatic build_random_text();
    int tokens;
    int depth_cap;
    int sel;
    text_buf.delete();
    gen_kinds.delete();
    tokens = $urandom_range(1, 40);
    depth_cap = ($urandom_range(0, 19) == 0) ? LEVELS + 2 : $urandom_range(2, 12);
    repeat (tokens) begin
      sel = $urandom_range(0, 99);
      if (sel < 25 && gen_kinds.size() < depth_cap) begin
        push_openers(1);
      end else if (sel < 45 && gen_kinds.size() > 0) begin
        push_closers(1);
      end else if (sel < 60) begin
        push_string();
      end else if (sel < 72) begin
        text_buf.push_back(blank_chars[$urandom_range(0, 4)]);
      end else if (sel < 88) begin
        text_buf.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                                      : 8'($urandom_range(8'h61, 8'h7A)));
      end else if (sel < 95) begin
        text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        text_buf.push_back(($urandom_range(0, 1) == 0) ? CH_RBRACE : CH_RBRACKET);
      end
    end
    if ($urandom_range(0, 9) < 7) push_closers(gen_kinds.size());
    if (text_buf.size() == 0) text_buf.push_back(blank_chars[$urandom_range(0, 4)]);
  endtask

  task automatic test_directed();
    send_literal("{,}");
    send_literal("]");
    send_literal("[}");
    send_literal("[\"\\ \t\"\"]");
    send_literal("\"\\\\\"}");
    text_buf.delete();
    text_buf.push_back(CH_LBRACE);
    text_buf.push_back(8'hFF);
    text_buf.push_back(8'h00);
    send_buffer();
    send_literal("]x");
  endtask

  task automatic test_deep_nesting();
    text_buf.delete();
    gen_kinds.delete();
    push_openers(LEVELS);
    push_closers(LEVELS);
    send_buffer();

    text_buf.delete();
    gen_kinds.delete();
    push_openers(LEVELS + 1);
    repeat (3) text_buf.push_back(8'($urandom_range(0, 255)));
    send_buffer();

    text_buf.delete();
    gen_kinds.delete();
    push_openers(LEVELS);
    text_buf.push_back(CH_SPACE);
    send_buffer();
  endtask

  task automatic test_random_texts();
    int start_count;
    start_count = requests_sent;
    while (requests_sent - start_count < RANDOM_REQUESTS) begin
      build_random_text();
      send_buffer();
    end
  endtask

  task automatic wait_drain();
    text_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  initial begin
    clear_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_deep_nesting();
    test_random_texts();
    wait_drain();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/jbb_pkg.sv
design/json_bracket_balance_checker.sv
tb/tb.sv
